[hdl/wsl_pkg.sv]
// ----------------------------------------------------------------------------
// WS2812 LED serializer package
// Shared types, register indexes and constants for the serializer blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package wsl_pkg;

  // Default number of LEDs held in the color store.
  localparam int MAX_LEDS_DEFAULT = 64;

  // Fixed field and counter widths.
  localparam int OP_W      = 2;
  localparam int IDX_W     = 6;
  localparam int COLOR_W   = 24;
  localparam int SLOT_W    = 11;
  localparam int TICK_W    = 8;
  localparam int CNT_W     = 11;
  localparam int FS_W      = 16;
  localparam int LED_W     = 7;
  localparam int BITSEL_W  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 8;

  // Frame shape constants.
  localparam int TRAIL_SLOTS = 24;

  // Reciprocal of three for an eight-bit dividend, scaled by 2^9.
  localparam logic [15:0] DIV3_MUL = 16'd171;

  // Register reset values.
  localparam logic [7:0] SLOT_TICKS_RST  = 8'd104;
  localparam logic [7:0] HIGH_TIME_RST   = 8'd56;
  localparam logic [7:0] LOW_TIME_RST    = 8'd28;
  localparam logic [7:0] RESET_SLOTS_RST = 8'd50;
  localparam logic [6:0] LED_COUNT_RST   = 7'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TIME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd4;

  // Operation codes of an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_SET     = 2'd0,
    OP_REFRESH = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Configuration register set.
  typedef struct packed {
    logic [7:0] slot_ticks;
    logic [7:0] high_time;
    logic [7:0] low_time;
    logic [7:0] reset_slots;
    logic [6:0] led_count;
  } cfg_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   led_index;
    logic [COLOR_W-1:0] color;
    logic               rejected;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic line;
    logic busy;
    logic frame_done;
    logic rejected;
  } res_t;

endpackage

`default_nettype wire

[hdl/wsl_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module wsl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/wsl_front.sv]
// ----------------------------------------------------------------------------
// WS2812 serializer front end
// Accepts input beats, decodes the operation and range-checks set-color
// indexes, then pushes the classified item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wsl_front import wsl_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [IDX_W-1:0]   led_index_i,
  input  logic [COLOR_W-1:0] color_i,
  input  logic [6:0]         led_count_i,
  input  logic               q_full_i,
  input  logic               clearing_i,
  output logic               push_o,
  output item_t              item_o
);

  logic [CNT_W-1:0] idx_ext;
  logic             out_of_range;

  // Stall while the queue is full or the color store is being cleared.
  assign in_stall_o = q_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  // A set color past the programmed count or the store depth is refused.
  assign idx_ext      = CNT_W'(led_index_i);
  assign out_of_range = (CNT_W'(led_count_i) <= idx_ext) ||
                        (CNT_W'(MAX_LEDS) <= idx_ext);

  always_comb begin
    item_o.op        = op_e'(op_i);
    item_o.led_index = led_index_i;
    item_o.color     = color_i;
    item_o.rejected  = (op_e'(op_i) == OP_SET) & out_of_range;
  end

endmodule

`default_nettype wire

[hdl/wsl_queue.sv]
// ----------------------------------------------------------------------------
// WS2812 serializer item queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wsl_queue import wsl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  item_t         store_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = store_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue fill count exceeds depth");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

[hdl/wsl_back.sv]
// ----------------------------------------------------------------------------
// WS2812 serializer back end
// Runs the frame position counters, keeps the color store, looks up the
// bit under the current slot and registers one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module wsl_back import wsl_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  output logic  clearing_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  res_o
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  // Lookup stage contents, waiting for the store read data.
  typedef struct packed {
    logic                active;
    logic                one_hi;
    logic                zero_hi;
    logic [BITSEL_W-1:0] bitsel;
    logic                fwd;
    logic                fwd_bit;
    logic                busy;
    logic                frame_done;
    logic                rejected;
  } look_t;

  // Frame position state.
  logic              sending_q, sending_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic              done_d;

  // Store clearing pass after reset.
  logic              clearing_q, clearing_d;
  logic [AW-1:0]     clr_q, clr_d;

  // Pipeline control.
  logic              a_valid_q, a_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              a_adv;
  logic              pop;
  look_t             a_q, a_d;
  res_t              res_q, res_d;

  // Position decode.
  logic              is_refresh;
  logic              e_send;
  logic [SLOT_W-1:0] e_slot;
  logic [TICK_W-1:0] e_tick;
  logic [SLOT_W-1:0] rs_ext;
  logic              in_data;
  logic [SLOT_W-1:0] d_slot;
  logic [15:0]       prod;
  logic [LED_W-1:0]  led;
  logic [SLOT_W-1:0] led_base;
  logic [SLOT_W-1:0] rem;
  logic [4:0]        pos;
  logic [1:0]        byte_sel;
  logic [CNT_W-1:0]  leds_sent;
  logic [FS_W-1:0]   frame_slots;
  logic [TICK_W-1:0] tick_inc;

  // Store ports.
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [COLOR_W-1:0] st_wdata;
  logic [AW-1:0]     st_raddr;
  logic [COLOR_W-1:0] st_rdata;
  logic              set_wr;
  logic              bit_val;

  // Handshake between the queue, the lookup stage and the output register.
  assign a_adv      = a_valid_q & (~out_valid_q | ~out_stall_i);
  assign pop        = q_valid_i & ~clearing_q & (~a_valid_q | a_adv);
  assign q_pop_o    = pop;
  assign clearing_o = clearing_q;

  // LEDs actually sent and frame length in slots.
  assign leds_sent   = (CNT_W'(cfg_i.led_count) > CNT_W'(MAX_LEDS)) ?
                       CNT_W'(MAX_LEDS) : CNT_W'(cfg_i.led_count);
  assign frame_slots = FS_W'(cfg_i.reset_slots) + (FS_W'(leds_sent) << 4) +
                       (FS_W'(leds_sent) << 3) + FS_W'(TRAIL_SLOTS);

  // Position that the line level is taken from: a refresh restarts it.
  assign is_refresh = (q_item_i.op == OP_REFRESH);
  assign e_send     = is_refresh | sending_q;
  assign e_slot     = is_refresh ? '0 : slot_q;
  assign e_tick     = is_refresh ? '0 : tick_q;

  // Split the data slot into LED number and bit position; divide by 24 as
  // a shift by three and a reciprocal multiply by three.
  assign rs_ext   = SLOT_W'(cfg_i.reset_slots);
  assign in_data  = (e_slot >= rs_ext);
  assign d_slot   = e_slot - rs_ext;
  assign prod     = {8'd0, d_slot[SLOT_W-1:3]} * DIV3_MUL;
  assign led      = prod[15:9];
  assign led_base = (SLOT_W'(led) << 4) + (SLOT_W'(led) << 3);
  assign rem      = d_slot - led_base;
  assign pos      = rem[4:0];

  // Green is sent first, then red, then blue, each MSB first.
  always_comb begin
    case (pos[4:3])
      2'd0:    byte_sel = 2'd1;
      2'd1:    byte_sel = 2'd2;
      default: byte_sel = 2'd0;
    endcase
  end

  // Store write port: clearing pass or an accepted set color.
  assign set_wr   = pop & (q_item_i.op == OP_SET) & ~q_item_i.rejected;
  assign st_we    = clearing_q | set_wr;
  assign st_waddr = clearing_q ? clr_q : AW'(q_item_i.led_index);
  assign st_wdata = clearing_q ? '0 : q_item_i.color;
  assign st_raddr = AW'(led);

  // Lookup stage next value.
  always_comb begin
    a_d.active     = e_send & in_data & (CNT_W'(led) < leds_sent);
    a_d.one_hi     = (e_tick < cfg_i.high_time);
    a_d.zero_hi    = (e_tick < cfg_i.low_time);
    a_d.bitsel     = {byte_sel, ~pos[2:0]};
    a_d.fwd        = set_wr & (st_waddr == st_raddr);
    a_d.fwd_bit    = q_item_i.color[{byte_sel, ~pos[2:0]}];
    a_d.busy       = sending_d;
    a_d.frame_done = done_d;
    a_d.rejected   = q_item_i.rejected;
  end

  // Frame position update for the popped item.
  always_comb begin
    sending_d = sending_q;
    slot_d    = slot_q;
    tick_d    = tick_q;
    done_d    = 1'b0;
    tick_inc  = tick_q + TICK_W'(1);
    if (pop) begin
      case (q_item_i.op)
        OP_REFRESH: begin
          sending_d = 1'b1;
          slot_d    = '0;
          tick_d    = '0;
        end
        OP_TICK: begin
          if (sending_q) begin
            if (tick_inc == cfg_i.slot_ticks) begin
              tick_d = '0;
              if ((FS_W'(slot_q) + FS_W'(1)) >= frame_slots) begin
                sending_d = 1'b0;
                slot_d    = '0;
                done_d    = 1'b1;
              end else begin
                slot_d = slot_q + SLOT_W'(1);
              end
            end else begin
              tick_d = tick_inc;
            end
          end
        end
        default: begin
          sending_d = sending_q;
        end
      endcase
    end
  end

  // Clearing pass walks every store entry once after reset.
  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + AW'(1);
      if (clr_q == AW'(MAX_LEDS - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // Stage valid flags.
  always_comb begin
    a_valid_d   = a_valid_q;
    out_valid_d = out_valid_q;
    if (pop) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
    if (a_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Line level from the stored or just-written color bit.
  assign bit_val = a_q.fwd ? a_q.fwd_bit : st_rdata[a_q.bitsel];

  always_comb begin
    res_d.line       = a_q.active & (bit_val ? a_q.one_hi : a_q.zero_hi);
    res_d.busy       = a_q.busy;
    res_d.frame_done = a_q.frame_done;
    res_d.rejected   = a_q.rejected;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q   <= 1'b0;
      slot_q      <= '0;
      tick_q      <= '0;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sending_q   <= sending_d;
      slot_q      <= slot_d;
      tick_q      <= tick_d;
      clearing_q  <= clearing_d;
      clr_q       <= clr_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_q <= a_d;
    end
    if (a_adv) begin
      res_q <= res_d;
    end
  end

  wsl_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (pop),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // The beat that ends a frame never reports the frame as still running.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_done) |-> !res_q.busy)
    else $error("frame_done with busy set");

  // Outside a frame the position counters rest at zero.
  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (slot_q == '0 && tick_q == '0))
    else $error("position counters not at zero while idle");

  // No item is taken while the store is being cleared.
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !pop)
    else $error("item popped during clearing pass");

  // A lookup entry that cannot move on is kept.
  a_look_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !a_adv) |=> a_valid_q)
    else $error("lookup stage entry lost");

endmodule

`default_nettype wire

[hdl/ws2812_led_serializer.sv]
// ----------------------------------------------------------------------------
// WS2812 LED serializer
// Color store and serial line generator for a chain of WS2812 LEDs.
// ----------------------------------------------------------------------------
// Each input beat is a set color, a refresh or a tick, and each one gives
// exactly one result beat. The block takes one beat per clock cycle
// sustained while the result channel is not stalled; each taken beat passes
// through the queue, the lookup stage with the color store read and then
// the output register. The frame position update in the back end sets
// that rate. After reset the color store is cleared one entry per cycle,
// every one of its MAX_LEDS entries, during which in_stall_o stays high;
// configuration writes are taken at any time and should be made only while
// no beat is in flight.
`default_nettype none

module ws2812_led_serializer import wsl_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [IDX_W-1:0]     led_index_i,
  input  logic [COLOR_W-1:0]   color_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 line_o,
  output logic                 busy_res_o,
  output logic                 frame_done_o,
  output logic                 rejected_o
);

  cfg_t  cfg_q, cfg_d;
  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  logic  clearing;
  res_t  res;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SLOT_TICKS:  cfg_d.slot_ticks  = cfg_data_i;
        REG_HIGH_TIME:   cfg_d.high_time   = cfg_data_i;
        REG_LOW_TIME:    cfg_d.low_time    = cfg_data_i;
        REG_RESET_SLOTS: cfg_d.reset_slots = cfg_data_i;
        REG_LED_COUNT:   cfg_d.led_count   = cfg_data_i[6:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_ticks  <= SLOT_TICKS_RST;
      cfg_q.high_time   <= HIGH_TIME_RST;
      cfg_q.low_time    <= LOW_TIME_RST;
      cfg_q.reset_slots <= RESET_SLOTS_RST;
      cfg_q.led_count   <= LED_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wsl_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .led_index_i (led_index_i),
    .color_i     (color_i),
    .led_count_i (cfg_q.led_count),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .push_o      (push),
    .item_o      (push_item)
  );

  wsl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  wsl_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign line_o       = res.line;
  assign busy_res_o   = res.busy;
  assign frame_done_o = res.frame_done;
  assign rejected_o   = res.rejected;

endmodule

`default_nettype wire

[tb/sv/ws2812_line_checker.sv]
// ----------------------------------------------------------------------------
// WS2812 serial line checker
// Watches the register, input and result channels of the LED serializer,
// keeps its own copy of the color store, frame position and registers, and
// compares every result beat with the level, busy, frame done and reject
// flags that the accepted input beat should give.
// ----------------------------------------------------------------------------
module ws2812_line_checker import wsl_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Register write channel.
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Input channel.
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [OP_W-1:0]      op_i,
  input  logic [IDX_W-1:0]     led_index_i,
  input  logic [COLOR_W-1:0]   color_i,
  // Result channel.
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 line_i,
  input  logic                 busy_res_i,
  input  logic                 frame_done_i,
  input  logic                 rejected_i,
  // Status for the testbench top.
  output int unsigned          fail_cnt_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the block state and registers.
  logic [COLOR_W-1:0] pixels [MAX_LEDS];
  logic               sending;
  logic [SLOT_W-1:0]  slot_idx;
  logic [TICK_W-1:0]  tick;
  cfg_t               cfg;

  // Results still owed by the block, oldest first.
  res_t        line_results_q [$];
  int unsigned mismatch_cnt;

  // Number of LEDs that a frame carries; larger counts saturate.
  function automatic int leds_in_frame();
    return (int'(cfg.led_count) > MAX_LEDS) ? MAX_LEDS : int'(cfg.led_count);
  endfunction

  // Total slots in a frame: reset slots, LED data and trailing low slots.
  function automatic int frame_len();
    return int'(cfg.reset_slots) + leds_in_frame() * 24 + TRAIL_SLOTS;
  endfunction

  // Level that the current frame position drives.
  function automatic logic line_level();
    int   d;
    int   led;
    int   pos;
    int   sel;
    logic one;
    if (!sending || int'(slot_idx) < int'(cfg.reset_slots)) begin
      return 1'b0;
    end
    d   = int'(slot_idx) - int'(cfg.reset_slots);
    led = d / 24;
    if (led >= leds_in_frame()) begin
      return 1'b0;
    end
    pos = d % 24;
    // Bytes go out green, red, blue, each MSB first.
    case (pos / 8)
      0:       sel = 15 - pos % 8;
      1:       sel = 23 - pos % 8;
      default: sel = 7 - pos % 8;
    endcase
    one = pixels[led][sel];
    return (tick < (one ? cfg.high_time : cfg.low_time));
  endfunction

  // Apply one input beat to the shadow state and give its result.
  function automatic res_t step_line(input op_e op, input logic [IDX_W-1:0] idx,
                                     input logic [COLOR_W-1:0] col);
    res_t r;
    r = '0;
    case (op)
      OP_SET: begin
        if (int'(idx) >= int'(cfg.led_count) || int'(idx) >= MAX_LEDS) begin
          r.rejected = 1'b1;
        end else begin
          pixels[idx] = col;
        end
        r.line = line_level();
      end
      OP_REFRESH: begin
        sending  = 1'b1;
        slot_idx = '0;
        tick     = '0;
        r.line   = line_level();
      end
      OP_TICK: begin
        r.line = line_level();
        if (sending) begin
          // The tick counter is eight bits wide and wraps, so a zero period
          // gives 256-tick slots.
          tick = tick + 8'd1;
          if (tick == cfg.slot_ticks) begin
            tick = '0;
            if (int'(slot_idx) + 1 >= frame_len()) begin
              sending      = 1'b0;
              slot_idx     = '0;
              r.frame_done = 1'b1;
            end else begin
              slot_idx = slot_idx + SLOT_W'(1);
            end
          end
        end
      end
      default: begin
        r.line = line_level();
      end
    endcase
    r.busy = sending;
    return r;
  endfunction

  // Track register writes, predict on each input beat, check each result beat.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEDS; i++) begin
        pixels[i] = '0;
      end
      sending      = 1'b0;
      slot_idx     = '0;
      tick         = '0;
      cfg          = {SLOT_TICKS_RST, HIGH_TIME_RST, LOW_TIME_RST, RESET_SLOTS_RST,
                      LED_COUNT_RST};
      mismatch_cnt = 0;
      line_results_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SLOT_TICKS:  cfg.slot_ticks  = cfg_data_i;
          REG_HIGH_TIME:   cfg.high_time   = cfg_data_i;
          REG_LOW_TIME:    cfg.low_time    = cfg_data_i;
          REG_RESET_SLOTS: cfg.reset_slots = cfg_data_i;
          REG_LED_COUNT:   cfg.led_count   = cfg_data_i[LED_W-1:0];
          default: ;
        endcase
      end

      // Compare before pushing so a result never meets its own prediction.
      if (out_valid_i && !out_stall_i) begin
        got.line       = line_i;
        got.busy       = busy_res_i;
        got.frame_done = frame_done_i;
        got.rejected   = rejected_i;
        if (line_results_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: result beat with none expected: line %b busy %b done %b rej %b",
                     $realtime, got.line, got.busy, got.frame_done, got.rejected);
          end
        end else begin
          want = line_results_q.pop_front();
          if (got.line != want.line || got.busy != want.busy ||
              got.frame_done != want.frame_done || got.rejected != want.rejected) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: line/busy/done/rej expected %b %b %b %b, got %b %b %b %b",
                       $realtime, want.line, want.busy, want.frame_done, want.rejected,
                       got.line, got.busy, got.frame_done, got.rejected);
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        line_results_q.push_back(step_line(op_e'(op_i), led_index_i, color_i));
      end

      fail_cnt_o <= mismatch_cnt;
      pending_o  <= line_results_q.size();
    end
  end

endmodule

[tb/sv/ws2812_led_serializer_tb.sv]
// ----------------------------------------------------------------------------
// WS2812 LED serializer testbench
// Drives directed and random set color, refresh and tick beats through the
// serializer under a series of register settings, with random idle bursts on
// both channels, and leaves all checking to the line checker beside the block.
// ----------------------------------------------------------------------------
module ws2812_led_serializer_tb import wsl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES    = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 16;
  localparam int IDLE_LIMIT    = 2000;

  // One random phase: register values, beat count and mix of operations.
  typedef struct packed {
    cfg_t       regs;
    logic [7:0] beats;
    logic [3:0] refresh_pct;
    logic       start_refresh;
    logic       quiet;
  } phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SLOT_TICKS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  op_e                  op = OP_NONE;
  logic [IDX_W-1:0]     led_index = '0;
  logic [COLOR_W-1:0]   color = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 line;
  logic                 busy_res;
  logic                 frame_done;
  logic                 rejected;
  logic                 quiet = 1'b0;
  int unsigned          stall_left = 0;
  int unsigned          fail_cnt;
  int unsigned          pending;

  always #1 clk = ~clk;

  ws2812_led_serializer dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .led_index_i  (led_index),
    .color_i      (color),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .line_o       (line),
    .busy_res_o   (busy_res),
    .frame_done_o (frame_done),
    .rejected_o   (rejected)
  );

  ws2812_line_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .led_index_i  (led_index),
    .color_i      (color),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .line_i       (line),
    .busy_res_i   (busy_res),
    .frame_done_i (frame_done),
    .rejected_i   (rejected),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  // Result side back-pressure in bursts; none while a phase is quiet.
  always @(posedge clk) begin
    if (quiet) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if ($urandom_range(0, 99) < 6) begin
      stall_left <= $urandom_range(1, 19);
      out_stall  <= 1'b1;
    end
  end

  // End the run when no beat moves on any channel for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Phase plan: bit period, high time, low time, reset slots, LED count,
  // beats, refresh percentage, leading refresh, no idling.
  function automatic phase_t plan_of(input int p);
    case (p)
      0:       return {8'd2,   8'd1,   8'd1,   8'd0,   7'd1,   8'd110, 4'd2, 1'b1, 1'b0};
      1:       return {8'd1,   8'd1,   8'd1,   8'd0,   7'd0,   8'd70,  4'd4, 1'b1, 1'b0};
      2:       return {8'd3,   8'd2,   8'd1,   8'd1,   7'd2,   8'd80,  4'd0, 1'b1, 1'b1};
      3:       return {8'd4,   8'd0,   8'd255, 8'd2,   7'd1,   8'd60,  4'd2, 1'b1, 1'b0};
      // A long frame left running, then shortened below its current slot.
      4:       return {8'd1,   8'd1,   8'd1,   8'd20,  7'd2,   8'd75,  4'd0, 1'b1, 1'b0};
      5:       return {8'd1,   8'd1,   8'd1,   8'd0,   7'd0,   8'd30,  4'd3, 1'b0, 1'b0};
      6:       return {8'd0,   8'd40,  8'd20,  8'd0,   7'd3,   8'd60,  4'd0, 1'b1, 1'b1};
      7:       return {8'd255, 8'd255, 8'd1,   8'd255, 7'd127, 8'd40,  4'd2, 1'b1, 1'b0};
      8:       return {8'd2,   8'd2,   8'd0,   8'd0,   7'd3,   8'd80,  4'd2, 1'b1, 1'b0};
      default: return {8'd1,   8'd1,   8'd1,   8'd1,   7'd1,   8'd100, 4'd3, 1'b1, 1'b1};
    endcase
  endfunction

  // Present one input beat, maybe after an idle burst, and wait until taken.
  task automatic send_beat(input op_e kind, input logic [IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] col);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= kind;
    led_index <= idx;
    color     <= col;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every expected result beat has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back; bit 7 of the LED count is noise.
  task automatic write_config(input cfg_t c);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      case (i)
        0: begin cfg_index <= REG_SLOT_TICKS;  cfg_data <= c.slot_ticks;  end
        1: begin cfg_index <= REG_HIGH_TIME;   cfg_data <= c.high_time;   end
        2: begin cfg_index <= REG_LOW_TIME;    cfg_data <= c.low_time;    end
        3: begin cfg_index <= REG_RESET_SLOTS; cfg_data <= c.reset_slots; end
        default: begin
          cfg_index <= REG_LED_COUNT;
          cfg_data  <= {$urandom_range(0, 1) != 0, c.led_count};
        end
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    phase_t           plan;
    int unsigned      pick;
    op_e              kind;
    logic [IDX_W-1:0] idx;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at reset settings: store extremes, every operation,
    // a color written and a refresh issued while a frame is going out.
    send_beat(OP_NONE, '1, '1);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_SET, 6'd0, 24'hFFFFFF);
    send_beat(OP_SET, 6'd63, 24'h000000);
    send_beat(OP_SET, 6'd1, 24'h5AC381);
    send_beat(OP_REFRESH, '0, '0);
    repeat (3) send_beat(OP_TICK, '0, '0);
    send_beat(OP_SET, 6'd0, 24'h123456);
    send_beat(OP_REFRESH, '1, '1);
    send_beat(OP_TICK, '0, '0);

    // One-tick slots, high time past the period, two LEDs so that higher
    // indexes are rejected.
    settle();
    write_config({8'd1, 8'd255, 8'd1, 8'd0, 7'd2});
    send_beat(OP_SET, 6'd2, 24'hABCDEF);
    send_beat(OP_SET, 6'd63, 24'hFFFFFF);
    send_beat(OP_SET, 6'd0, 24'h800001);
    send_beat(OP_SET, 6'd1, 24'h00FF00);
    send_beat(OP_REFRESH, '0, '0);
    repeat (6) send_beat(OP_TICK, '0, '0);

    // Random phases: mostly a refresh followed by ticks, with color writes,
    // unused operations and stray refreshes mixed in.
    for (int p = 0; p < NUM_PHASES; p++) begin
      plan = plan_of(p);
      settle();
      write_config(plan.regs);
      quiet <= plan.quiet;
      for (int i = 0; i < plan.beats; i++) begin
        pick = $urandom_range(0, 99);
        if (i == 0 && plan.start_refresh) begin
          kind = OP_REFRESH;
        end else if (pick < plan.refresh_pct) begin
          kind = OP_REFRESH;
        end else if (pick < plan.refresh_pct + 12) begin
          kind = OP_SET;
        end else if (pick < plan.refresh_pct + 15) begin
          kind = OP_NONE;
        end else begin
          kind = OP_TICK;
        end
        if ($urandom_range(0, 9) < 7) begin
          idx = IDX_W'($urandom_range(0, 3));
        end else begin
          idx = IDX_W'($urandom_range(0, 63));
        end
        send_beat(kind, idx, COLOR_W'($urandom));
      end
    end

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
